[hdl/ucl_pkg.sv]
// Shared constants, codes and controller/datapath interface types of the command-line receiver.
package ucl_pkg;

  localparam int LINE_DEPTH = 32;
  localparam int IDX_W      = $clog2(LINE_DEPTH + 1);
  localparam int ADDR_W     = $clog2(LINE_DEPTH);

  localparam int CHAR_W  = 8;
  localparam int LEN_W   = 6;
  localparam int KIND_W  = 3;
  localparam int TICK_W  = 9;
  localparam int LIMIT_W = 8;

  localparam logic [LIMIT_W-1:0] TIMEOUT_RESET = 8'd10;
  localparam logic [TICK_W-1:0]  TICK_MAX      = 9'h1ff;
  localparam logic [CHAR_W-1:0]  CHAR_Z        = 8'h7a;
  localparam logic [CHAR_W-1:0]  CHAR_NL       = 8'h0a;

  typedef enum logic [KIND_W-1:0] {
    KIND_PROMPT   = 3'd0,
    KIND_OVERRUN  = 3'd1,
    KIND_OVERFLOW = 3'd2,
    KIND_CHAR     = 3'd3,
    KIND_END      = 3'd4,
    KIND_TIMEOUT  = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    CASE_NONE,
    CASE_SINGLE,
    CASE_LINE
  } case_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SEND,
    ST_END
  } state_e;

  typedef struct packed {
    logic take_item;
    logic exec;
    logic send_char;
    logic send_end;
  } ctrl_cmd_t;

  typedef struct packed {
    case_e item_case;
    logic  out_free;
    logic  len_zero;
    logic  last_char;
  } dp_status_t;

endpackage

[hdl/ucl_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module ucl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/ucl_ctrl.sv]
// Controller state machine that sequences request intake, execution and line emission.
module ucl_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ucl_pkg::dp_status_t   status_i,
  output ucl_pkg::ctrl_cmd_t    cmd_o
);

  ucl_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ucl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ucl_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ucl_pkg::ST_EXEC;
        end
      end
      ucl_pkg::ST_EXEC: begin
        if (status_i.item_case == ucl_pkg::CASE_LINE) begin
          state_d = status_i.len_zero ? ucl_pkg::ST_END : ucl_pkg::ST_READ;
        end else if (status_i.item_case == ucl_pkg::CASE_NONE || status_i.out_free) begin
          state_d = ucl_pkg::ST_IDLE;
        end
      end
      ucl_pkg::ST_READ: begin
        state_d = ucl_pkg::ST_SEND;
      end
      ucl_pkg::ST_SEND: begin
        if (status_i.out_free) begin
          state_d = status_i.last_char ? ucl_pkg::ST_END : ucl_pkg::ST_READ;
        end
      end
      ucl_pkg::ST_END: begin
        if (status_i.out_free) begin
          state_d = ucl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ucl_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o.take_item = 1'b0;
    cmd_o.exec      = 1'b0;
    cmd_o.send_char = 1'b0;
    cmd_o.send_end  = 1'b0;
    case (state_q)
      ucl_pkg::ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.take_item = in_valid_i;
      end
      ucl_pkg::ST_EXEC: begin
        cmd_o.exec = (status_i.item_case != ucl_pkg::CASE_SINGLE) || status_i.out_free;
      end
      ucl_pkg::ST_READ: begin
      end
      ucl_pkg::ST_SEND: begin
        cmd_o.send_char = status_i.out_free;
      end
      ucl_pkg::ST_END: begin
        cmd_o.send_end = status_i.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

[hdl/ucl_datapath.sv]
// Datapath: receiver state registers, line store, emission counter and result register.
module ucl_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ucl_pkg::ctrl_cmd_t            cmd_i,
  output ucl_pkg::dp_status_t           status_o,
  input  logic                          command_i,
  input  logic [ucl_pkg::CHAR_W-1:0]    rx_byte_i,
  input  logic                          framing_error_i,
  input  logic                          overrun_error_i,
  input  logic                          cfg_we_i,
  input  logic [ucl_pkg::LIMIT_W-1:0]   cfg_wdata_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [ucl_pkg::KIND_W-1:0]    event_kind_o,
  output logic [ucl_pkg::CHAR_W-1:0]    char_out_o,
  output logic [ucl_pkg::LEN_W-1:0]     line_length_o,
  output logic                          receiving_o,
  output logic                          last_o
);

  // Latched request.
  logic                        cmd_q;
  logic [ucl_pkg::CHAR_W-1:0]  byte_q;
  logic                        ferr_q;
  logic                        oerr_q;

  // Receiver state.
  logic                        mode_q, mode_d;
  logic [ucl_pkg::IDX_W-1:0]   wi_q, wi_d;
  logic                        timer_q, timer_d;
  logic [ucl_pkg::TICK_W-1:0]  tick_q, tick_d;
  logic [ucl_pkg::LIMIT_W-1:0] limit_q;
  logic [ucl_pkg::IDX_W-1:0]   len_q, len_calc;
  logic [ucl_pkg::IDX_W-1:0]   rd_cnt_q;

  // Result register.
  logic                        out_valid_q;
  ucl_pkg::kind_e              out_kind_q;
  logic [ucl_pkg::CHAR_W-1:0]  out_char_q;
  logic [ucl_pkg::LEN_W-1:0]   out_len_q;
  logic                        out_recv_q;
  logic                        out_last_q;

  ucl_pkg::case_e              item_case;
  ucl_pkg::kind_e              single_kind;
  logic                        store;
  logic                        out_free;
  logic                        load_single;
  logic [ucl_pkg::CHAR_W-1:0]  ram_rdata;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      cmd_q  <= command_i;
      byte_q <= rx_byte_i;
      ferr_q <= framing_error_i;
      oerr_q <= overrun_error_i;
    end
  end

  // Decision for the latched request, in the priority order of the receiver.
  always_comb begin
    item_case   = ucl_pkg::CASE_NONE;
    single_kind = ucl_pkg::KIND_PROMPT;
    mode_d      = mode_q;
    wi_d        = wi_q;
    timer_d     = timer_q;
    tick_d      = tick_q;
    store       = 1'b0;
    if (cmd_q) begin
      if (timer_q) begin
        if (tick_q > {1'b0, limit_q}) begin
          item_case   = ucl_pkg::CASE_SINGLE;
          single_kind = ucl_pkg::KIND_TIMEOUT;
          mode_d      = 1'b0;
          wi_d        = '0;
          timer_d     = 1'b0;
          tick_d      = '0;
        end else if (tick_q != ucl_pkg::TICK_MAX) begin
          tick_d = tick_q + 1'b1;
        end
      end
    end else if (ferr_q) begin
      item_case   = ucl_pkg::CASE_SINGLE;
      single_kind = ucl_pkg::KIND_PROMPT;
      mode_d      = 1'b1;
      wi_d        = '0;
      timer_d     = 1'b1;
      tick_d      = '0;
    end else if (oerr_q) begin
      item_case   = ucl_pkg::CASE_SINGLE;
      single_kind = ucl_pkg::KIND_OVERRUN;
      wi_d        = '0;
    end else if (wi_q >= ucl_pkg::IDX_W'(ucl_pkg::LINE_DEPTH)) begin
      item_case   = ucl_pkg::CASE_SINGLE;
      single_kind = ucl_pkg::KIND_OVERFLOW;
      wi_d        = '0;
    end else if (wi_q == '0 && byte_q > ucl_pkg::CHAR_Z) begin
      item_case = ucl_pkg::CASE_NONE;
    end else begin
      store = 1'b1;
      if (byte_q == ucl_pkg::CHAR_NL) begin
        item_case = ucl_pkg::CASE_LINE;
        mode_d    = 1'b0;
        wi_d      = '0;
        timer_d   = 1'b0;
        tick_d    = '0;
      end else begin
        wi_d = wi_q + 1'b1;
      end
    end
  end

  // The newline lands at wi_q, so the line holds wi_q + 1 bytes and the payload wi_q - 1.
  assign len_calc = (wi_q < ucl_pkg::IDX_W'(2)) ? '0 : wi_q - 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      wi_q     <= '0;
      timer_q  <= 1'b0;
      tick_q   <= '0;
      limit_q  <= ucl_pkg::TIMEOUT_RESET;
      len_q    <= '0;
      rd_cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (cmd_i.exec) begin
        mode_q   <= mode_d;
        wi_q     <= wi_d;
        timer_q  <= timer_d;
        tick_q   <= tick_d;
        len_q    <= len_calc;
        rd_cnt_q <= '0;
      end else if (cmd_i.send_char) begin
        rd_cnt_q <= rd_cnt_q + 1'b1;
      end
    end
  end

  ucl_ram #(
    .WIDTH (ucl_pkg::CHAR_W),
    .DEPTH (ucl_pkg::LINE_DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.exec && store),
    .waddr_i (wi_q[ucl_pkg::ADDR_W-1:0]),
    .wdata_i (byte_q),
    .raddr_i (rd_cnt_q[ucl_pkg::ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign out_free    = !out_valid_q || out_ready_i;
  assign load_single = cmd_i.exec && (item_case == ucl_pkg::CASE_SINGLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_single || cmd_i.send_char || cmd_i.send_end) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_single) begin
      out_kind_q <= single_kind;
      out_char_q <= '0;
      out_len_q  <= '0;
      out_recv_q <= mode_d;
      out_last_q <= 1'b1;
    end else if (cmd_i.send_char) begin
      out_kind_q <= ucl_pkg::KIND_CHAR;
      out_char_q <= ram_rdata;
      out_len_q  <= '0;
      out_recv_q <= mode_q;
      out_last_q <= 1'b0;
    end else if (cmd_i.send_end) begin
      out_kind_q <= ucl_pkg::KIND_END;
      out_char_q <= '0;
      out_len_q  <= ucl_pkg::LEN_W'(len_q);
      out_recv_q <= mode_q;
      out_last_q <= 1'b1;
    end
  end

  assign status_o.item_case = item_case;
  assign status_o.out_free  = out_free;
  assign status_o.len_zero  = (len_calc == '0);
  assign status_o.last_char = (ucl_pkg::IDX_W'(rd_cnt_q + 1'b1) == len_q);

  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = out_kind_q;
  assign char_out_o    = out_char_q;
  assign line_length_o = out_len_q;
  assign receiving_o   = out_recv_q;
  assign last_o        = out_last_q;

endmodule

[hdl/uart_command_line_receiver.sv]
// Top level of the UART command-line receiver: stream ports, controller and datapath.
//
//   Channel   Direction  Signals                             Carries
//   s_axis    in         tvalid/tready/tdata[15:0]/tuser[0]  received byte or timer tick
//   m_axis    out        tvalid/tready/tdata[15:0]/tuser     events, tlast closes a request
//   cfg       in         cfg_we_i/cfg_wdata_i[7:0]           timeout limit (reset value 10)
//
// A request is taken in the idle state and executed in the execute state; a request that
// produces one event waits there until the result register is free. A newline request
// then reads the line store, whose read port is registered, alternating a read state and
// a send state for each character before the line end state, with a line of at most
// LINE_DEPTH - 2 characters; downstream stalls hold the send and line end states.
// Reset is asynchronous and active low; the line store is not cleared, since only entries
// written since the write index was last cleared are ever read. A stalled m_axis side
// holds the result register; the next request is still taken while it waits.
module uart_command_line_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Timeout limit register.
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] rx_byte, [8] framing_error,
                                      // [9] overrun_error, [15:10] zero
  input  logic [0:0]  s_axis_tuser,   // [0] command

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] char_out, [13:8] line_length,
                                      // [14] receiving, [15] zero
  output logic [2:0]  m_axis_tuser,   // [2:0] event_kind
  output logic        m_axis_tlast    // last event caused by the request
);

  ucl_pkg::ctrl_cmd_t  cmd;
  ucl_pkg::dp_status_t status;

  logic [ucl_pkg::CHAR_W-1:0] char_out;
  logic [ucl_pkg::LEN_W-1:0]  line_length;
  logic                       receiving;

  // The controller decides when a request is taken, executed and when each
  // line character or line end is pushed into the result register.
  ucl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the receive mode, write index, timer, line store and
  // the output register that decouples the two stream sides.
  ucl_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .command_i       (s_axis_tuser[0]),
    .rx_byte_i       (s_axis_tdata[7:0]),
    .framing_error_i (s_axis_tdata[8]),
    .overrun_error_i (s_axis_tdata[9]),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .event_kind_o    (m_axis_tuser),
    .char_out_o      (char_out),
    .line_length_o   (line_length),
    .receiving_o     (receiving),
    .last_o          (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, receiving, line_length, char_out};

  // A request is executed one at a time, so intake closes right after a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while the previous one was still executing");

  // Line characters never close a request; every other event does.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tuser == ucl_pkg::KIND_CHAR) != m_axis_tlast))
    else $error("tlast does not match the event kind");

  // Line characters and line ends are emitted after receive mode was left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ucl_pkg::KIND_CHAR || m_axis_tuser == ucl_pkg::KIND_END)
    |-> !m_axis_tdata[14])
    else $error("line output reported with receive mode still set");

  // Only the line end carries a length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ucl_pkg::KIND_END) |-> m_axis_tdata[13:8] == '0)
    else $error("nonzero line length on an event other than a line end");

endmodule

[dv/tb_uart_command_line_receiver.sv]
// Self-checking testbench for the UART command-line receiver: stream stimulus and event checks.
module tb_uart_command_line_receiver;
  import ucl_pkg::*;

  // One request on the input stream: a received byte or a timer tick.
  typedef struct {
    logic              tick;
    logic [CHAR_W-1:0] data;
    logic              framing;
    logic              overrun;
  } rx_req_t;

  // One event on the output stream.
  typedef struct {
    kind_e             kind;
    logic [CHAR_W-1:0] ch;
    logic [LEN_W-1:0]  len;
    logic              receiving;
    logic              last;
  } line_evt_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  uart_command_line_receiver u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  rx_req_t   pending_requests[$];
  line_evt_t owed_events[$];
  int        queued_items;
  int        mismatch_count;
  bit        req_taken;
  bit        no_idle;

  // Shadow copy of the receiver state, advanced once per accepted request.
  logic               rx_mode;
  int                 wr_idx;
  logic               timer_on;
  int                 ticks;
  logic [CHAR_W-1:0]  line_copy [LINE_DEPTH];
  logic [LIMIT_W-1:0] timeout_limit_q;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  task automatic owe_event(input kind_e kind, input logic [CHAR_W-1:0] ch,
                           input logic [LEN_W-1:0] len, input logic last);
    line_evt_t e;
    e.kind      = kind;
    e.ch        = ch;
    e.len       = len;
    e.receiving = rx_mode;
    e.last      = last;
    owed_events.push_back(e);
  endtask

  // Works out the events one accepted request causes and updates the shadow state.
  task automatic compute_events(input rx_req_t r);
    int len;
    if (r.tick) begin
      // Ticks only matter while the timer runs.
      if (timer_on) begin
        if (ticks > int'(timeout_limit_q)) begin
          timer_on = 1'b0;
          ticks    = 0;
          wr_idx   = 0;
          rx_mode  = 1'b0;
          owe_event(KIND_TIMEOUT, '0, '0, 1'b1);
        end else if (ticks < int'(TICK_MAX)) begin
          ticks++;
        end
      end
    end else if (r.framing) begin
      rx_mode  = 1'b1;
      wr_idx   = 0;
      timer_on = 1'b1;
      ticks    = 0;
      owe_event(KIND_PROMPT, '0, '0, 1'b1);
    end else if (r.overrun) begin
      wr_idx = 0;
      owe_event(KIND_OVERRUN, '0, '0, 1'b1);
    end else if (wr_idx >= LINE_DEPTH) begin
      wr_idx = 0;
      owe_event(KIND_OVERFLOW, '0, '0, 1'b1);
    end else if (!(wr_idx == 0 && r.data > CHAR_Z)) begin
      line_copy[wr_idx] = r.data;
      wr_idx++;
      if (r.data == CHAR_NL) begin
        // The last two characters are dropped; a short line yields length zero.
        len      = (wr_idx >= 2) ? wr_idx - 2 : 0;
        wr_idx   = 0;
        rx_mode  = 1'b0;
        timer_on = 1'b0;
        ticks    = 0;
        for (int i = 0; i < len; i++) owe_event(KIND_CHAR, line_copy[i], '0, 1'b0);
        owe_event(KIND_END, '0, LEN_W'(len), 1'b1);
      end
    end
  endtask

  task automatic queue_byte(input logic [CHAR_W-1:0] b, input logic fe, input logic oe);
    rx_req_t r;
    r.tick    = 1'b0;
    r.data    = b;
    r.framing = fe;
    r.overrun = oe;
    pending_requests.push_back(r);
    queued_items++;
  endtask

  // The byte and flag bits of a tick are ignored by the block, so they are randomized.
  task automatic queue_tick();
    rx_req_t r;
    r.tick    = 1'b1;
    r.data    = CHAR_W'($urandom_range(255));
    r.framing = 1'($urandom_range(1));
    r.overrun = 1'($urandom_range(1));
    pending_requests.push_back(r);
    queued_items++;
  endtask

  // Mostly well-formed lines and timeout sequences with random content, plus noise.
  task automatic queue_random(input int count);
    int stop_at;
    int sel;
    int len;
    int nticks;
    stop_at = queued_items + count;
    while (queued_items < stop_at) begin
      sel = $urandom_range(99);
      if (sel < 55) begin
        if ($urandom_range(2) != 0) queue_byte(CHAR_W'($urandom_range(255)), 1'b1,
                                               1'($urandom_range(1)));
        if ($urandom_range(6) == 0) len = $urandom_range(LINE_DEPTH + 2, LINE_DEPTH - 4);
        else len = $urandom_range(8);
        repeat (len) begin
          if ($urandom_range(9) == 0) queue_byte(CHAR_W'($urandom_range(255)), 1'b0, 1'b0);
          else queue_byte(CHAR_W'($urandom_range(CHAR_Z, 8'h20)), 1'b0, 1'b0);
        end
        // Now and then an overrun spoils the line before its newline.
        if ($urandom_range(9) == 0) queue_byte(CHAR_W'($urandom_range(255)), 1'b0, 1'b1);
        queue_byte(CHAR_NL, 1'b0, 1'b0);
      end else if (sel < 70) begin
        queue_byte(CHAR_W'($urandom_range(255)), 1'b1, 1'b0);
        if (timeout_limit_q <= 8'd18 && $urandom_range(3) != 0)
          nticks = int'(timeout_limit_q) + 2;
        else
          nticks = $urandom_range(12);
        repeat (nticks) queue_tick();
      end else if ($urandom_range(3) == 0) begin
        queue_tick();
      end else begin
        queue_byte(CHAR_W'($urandom_range(255)), $urandom_range(7) == 0,
                   $urandom_range(5) == 0);
      end
    end
  endtask

  // Waits until every request is taken and every event has come, then lets the block settle.
  task automatic wait_idle();
    while (pending_requests.size() != 0 || s_axis_tvalid || owed_events.size() != 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    timeout_limit_q = value;
  endtask

  // Request driver: presents the next queued request once the previous one is taken.
  always @(negedge clk_i) begin : drive_requests
    rx_req_t next_req;
    if (rst_ni && (!s_axis_tvalid || req_taken)) begin
      if (pending_requests.size() != 0 && (no_idle || $urandom_range(99) >= 23)) begin
        next_req = pending_requests.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, next_req.overrun, next_req.framing, next_req.data};
        s_axis_tuser  <= next_req.tick;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= rst_ni && (no_idle || $urandom_range(99) >= 23);
  end

  // Monitor: checks each event against the oldest one owed, then records new requests.
  always @(posedge clk_i) begin : check_events
    line_evt_t want;
    rx_req_t   got_req;
    req_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (owed_events.size() == 0) begin
        $error("event with none expected: kind %0d data %0h", m_axis_tuser, m_axis_tdata);
        mismatch_count++;
      end else begin
        want = owed_events.pop_front();
        if (m_axis_tuser != want.kind) begin
          $error("event_kind: expected %0d, actual %0d", want.kind, m_axis_tuser);
          mismatch_count++;
        end
        if (m_axis_tdata[7:0] != want.ch) begin
          $error("char_out: expected %0h, actual %0h", want.ch, m_axis_tdata[7:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[13:8] != want.len) begin
          $error("line_length: expected %0d, actual %0d", want.len, m_axis_tdata[13:8]);
          mismatch_count++;
        end
        if (m_axis_tdata[14] != want.receiving) begin
          $error("receiving: expected %0b, actual %0b", want.receiving, m_axis_tdata[14]);
          mismatch_count++;
        end
        if (m_axis_tlast != want.last) begin
          $error("last: expected %0b, actual %0b", want.last, m_axis_tlast);
          mismatch_count++;
        end
      end
    end
    if (req_taken) begin
      got_req.tick    = s_axis_tuser[0];
      got_req.data    = s_axis_tdata[7:0];
      got_req.framing = s_axis_tdata[8];
      got_req.overrun = s_axis_tdata[9];
      compute_events(got_req);
    end
  end

  initial begin : run_test
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = '0;
    m_axis_tready   = 1'b0;
    no_idle         = 1'b0;
    queued_items    = 0;
    mismatch_count  = 0;
    rx_mode         = 1'b0;
    wr_idx          = 0;
    timer_on        = 1'b0;
    ticks           = 0;
    timeout_limit_q = TIMEOUT_RESET;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Tick with the timer stopped, then a byte above 'z' at the start of a line.
    queue_tick();
    queue_byte(8'hff, 1'b0, 1'b0);
    // Framing and overrun together: the break wins and gives a prompt.
    queue_byte(8'h00, 1'b1, 1'b1);
    // A zero byte at the first position and a high byte after it are stored and echoed.
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'hff, 1'b0, 1'b0);
    queue_byte("c", 1'b0, 1'b0);
    queue_byte(CHAR_NL, 1'b0, 1'b0);
    // Lines too short to keep any character, then one that keeps a single character.
    queue_byte(CHAR_NL, 1'b0, 1'b0);
    queue_byte("q", 1'b0, 1'b0);
    queue_byte(CHAR_NL, 1'b0, 1'b0);
    queue_byte("r", 1'b0, 1'b0);
    queue_byte("s", 1'b0, 1'b0);
    queue_byte(CHAR_NL, 1'b0, 1'b0);
    queue_byte("k", 1'b0, 1'b1);
    // After a break, '{' is dropped as the first byte but 'z' is kept.
    queue_byte(">", 1'b1, 1'b0);
    queue_byte(8'h7b, 1'b0, 1'b0);
    queue_byte(CHAR_Z, 1'b0, 1'b0);
    queue_byte("y", 1'b0, 1'b0);
    queue_byte(CHAR_NL, 1'b0, 1'b0);
    // A few ticks that stay under the default limit.
    queue_byte(8'h55, 1'b1, 1'b0);
    repeat (3) queue_tick();
    queue_random(60);
    wait_idle();

    // Smallest limit: the second tick after a break times out.
    write_limit(8'd0);
    queue_byte(8'haa, 1'b1, 1'b0);
    repeat (3) queue_tick();
    queue_random(70);
    wait_idle();

    // Largest limit, with both sides running without gaps.
    no_idle = 1'b1;
    write_limit(8'd255);
    queue_random(70);
    wait_idle();
    no_idle = 1'b0;

    write_limit(LIMIT_W'($urandom_range(20, 1)));
    queue_random(60);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("uart_command_line_receiver regression: pass");
    end else begin
      $display("uart_command_line_receiver regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #6000000;
    $display("uart_command_line_receiver regression: fail");
    $finish;
  end

endmodule
